@@ sv/mrt_pkg.sv @@
package mrt_pkg;

    // elapsed-tick counter width
    localparam int COUNT_WIDTH = 32;
    // width used to compare a counter against a 32-bit threshold
    localparam int CMP_WIDTH = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // func codes
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_ANALOG = 3'd1;
    localparam logic [2:0] FUNC_DIGIT  = 3'd2;
    localparam logic [2:0] FUNC_DECAY  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    // register indexes
    localparam logic [2:0] REG_ANALOG_LIMIT = 3'd0;
    localparam logic [2:0] REG_QUIET_HIGH   = 3'd1;
    localparam logic [2:0] REG_QUIET_LOW    = 3'd2;
    localparam logic [2:0] REG_MOTION_HOLD  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT      = 3'd4;
    localparam logic [2:0] REG_MAP_LOW      = 3'd5;
    localparam logic [2:0] REG_MAP_HIGH     = 3'd6;
    localparam logic [2:0] REG_NUDGE        = 3'd7;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    // register and state reset values
    localparam logic [15:0] RST_ANALOG_LIMIT = 16'd1023;
    localparam logic [15:0] RST_QUIET_HIGH   = 16'd515;
    localparam logic [15:0] RST_QUIET_LOW    = 16'd360;
    localparam logic [31:0] RST_MOTION_HOLD  = 32'd5000;
    localparam logic [31:0] RST_TIMEOUT      = 32'd60000;
    localparam logic [15:0] RST_MAP_LOW      = 16'd0;
    localparam logic [15:0] RST_MAP_HIGH     = 16'd255;
    localparam logic [15:0] RST_NUDGE        = 16'd200;
    localparam logic [15:0] RST_LAST_LEVEL   = 16'd420;
    localparam logic [15:0] RANGE_MIN_EMPTY  = 16'hFFFF;
    localparam logic [15:0] RANGE_MAX_EMPTY  = 16'h0000;

    // restoring divider: 32-bit dividend magnitude, one quotient bit per step
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

    typedef struct packed {
        logic apply;     // accepted beat: update state from func/sample
        logic prep;      // average and operand magnitudes
        logic mul;       // product into divider
        logic div_step;  // one quotient bit
        logic out_load;  // result into output register
    } mrt_cmd_t;

    typedef struct packed {
        logic div_done;  // current step is the last one
    } mrt_status_t;

endpackage

@@ sv/mrt_in_if.sv @@
interface mrt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink (input valid, input func, input sample, output ready);
endinterface

@@ sv/mrt_out_if.sv @@
interface mrt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] mapped_level;
    logic [15:0] range_average;
    logic        motion_active;
    logic        timed_out;

    modport source (output valid, output mapped_level, output range_average,
                    output motion_active, output timed_out, input ready);
    modport sink (input valid, input mapped_level, input range_average,
                  input motion_active, input timed_out, output ready);
endinterface

@@ sv/mrt_ctrl.sv @@
module mrt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mrt_pkg::mrt_status_t status,
    output mrt_pkg::mrt_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/mrt_datapath.sv @@
module mrt_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mrt_pkg::mrt_cmd_t                      cmd,
    output mrt_pkg::mrt_status_t                   status,
    input  logic [2:0]                             func,
    input  logic [15:0]                            sample,
    input  logic                                   cfg_we,
    input  logic [mrt_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [mrt_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    output logic [15:0]                            mapped_level,
    output logic [15:0]                            range_average,
    output logic                                   motion_active,
    output logic                                   timed_out
);

    localparam int CW = mrt_pkg::COUNT_WIDTH;
    localparam int XW = mrt_pkg::CMP_WIDTH;

    // configuration
    logic [15:0] analog_limit_reg, quiet_high_reg, quiet_low_reg;
    logic [31:0] motion_hold_reg, timeout_reg;
    logic [15:0] map_low_reg, map_high_reg, nudge_reg;

    // tracker state
    logic [15:0]   cur_max_reg, cur_max_next, cur_min_reg, cur_min_next;
    logic [15:0]   peak_max_reg, peak_max_next, peak_min_reg, peak_min_next;
    logic [15:0]   last_reg, last_next;
    logic [CW-1:0] tsm_reg, tsm_next, tsn_reg, tsn_next;

    // map pipeline and divider
    logic [15:0] avg_reg, mag_a_reg, mag_b_reg, dsor_reg;
    logic        neg_reg, zero_reg, motion_reg, tout_reg;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [mrt_pkg::DIV_CNT_WIDTH-1:0] cnt_reg;

    // result register
    logic [15:0] mapped_reg, avg_out_reg;
    logic        motion_out_reg, tout_out_reg;

    // ---- state update for one accepted beat ----
    logic [15:0] cmax_w, cmin_w, pmax_w, pmin_w;
    logic        moved, nudge_ok;

    always_comb
    begin
        cmax_w = (sample > cur_max_reg) ? sample : cur_max_reg;
        cmin_w = (sample < cur_min_reg) ? sample : cur_min_reg;
        pmax_w = (sample > peak_max_reg) ? sample : peak_max_reg;
        pmin_w = (sample < peak_min_reg) ? sample : peak_min_reg;
        if (cmax_w > analog_limit_reg)
            cmax_w = analog_limit_reg;
        if (pmax_w > analog_limit_reg)
            pmax_w = analog_limit_reg;
        moved    = (sample != 16'd0) || (last_reg > quiet_high_reg)
                   || (last_reg < quiet_low_reg);
        nudge_ok = XW'(tsn_reg) >= XW'(nudge_reg);

        cur_max_next  = cur_max_reg;
        cur_min_next  = cur_min_reg;
        peak_max_next = peak_max_reg;
        peak_min_next = peak_min_reg;
        last_next     = last_reg;
        tsm_next      = tsm_reg;
        tsn_next      = tsn_reg;
        case (func)
            mrt_pkg::FUNC_TICK:
            begin
                if (tsm_reg != mrt_pkg::CNT_MAX)
                    tsm_next = tsm_reg + CW'(1);
                if (tsn_reg != mrt_pkg::CNT_MAX)
                    tsn_next = tsn_reg + CW'(1);
            end
            mrt_pkg::FUNC_ANALOG:
            begin
                last_next     = (sample < analog_limit_reg) ? sample : analog_limit_reg;
                cur_max_next  = cmax_w;
                cur_min_next  = cmin_w;
                peak_max_next = pmax_w;
                peak_min_next = pmin_w;
            end
            mrt_pkg::FUNC_DIGIT:
            begin
                if (moved)
                    tsm_next = '0;
            end
            mrt_pkg::FUNC_DECAY:
            begin
                if (nudge_ok)
                begin
                    tsn_next = '0;
                    if (peak_max_reg > quiet_high_reg)
                        peak_max_next = peak_max_reg - 16'd1;
                    if (peak_min_reg < quiet_low_reg)
                        peak_min_next = peak_min_reg + 16'd1;
                end
            end
            mrt_pkg::FUNC_CLEAR:
            begin
                cur_max_next = mrt_pkg::RANGE_MAX_EMPTY;
                cur_min_next = mrt_pkg::RANGE_MIN_EMPTY;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            analog_limit_reg <= mrt_pkg::RST_ANALOG_LIMIT;
            quiet_high_reg   <= mrt_pkg::RST_QUIET_HIGH;
            quiet_low_reg    <= mrt_pkg::RST_QUIET_LOW;
            motion_hold_reg  <= mrt_pkg::RST_MOTION_HOLD;
            timeout_reg      <= mrt_pkg::RST_TIMEOUT;
            map_low_reg      <= mrt_pkg::RST_MAP_LOW;
            map_high_reg     <= mrt_pkg::RST_MAP_HIGH;
            nudge_reg        <= mrt_pkg::RST_NUDGE;
            cur_max_reg      <= mrt_pkg::RANGE_MAX_EMPTY;
            cur_min_reg      <= mrt_pkg::RANGE_MIN_EMPTY;
            peak_max_reg     <= mrt_pkg::RANGE_MAX_EMPTY;
            peak_min_reg     <= mrt_pkg::RANGE_MIN_EMPTY;
            last_reg         <= mrt_pkg::RST_LAST_LEVEL;
            tsm_reg          <= '0;
            tsn_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mrt_pkg::REG_ANALOG_LIMIT: analog_limit_reg <= cfg_data[15:0];
                    mrt_pkg::REG_QUIET_HIGH:   quiet_high_reg   <= cfg_data[15:0];
                    mrt_pkg::REG_QUIET_LOW:    quiet_low_reg    <= cfg_data[15:0];
                    mrt_pkg::REG_MOTION_HOLD:  motion_hold_reg  <= cfg_data[31:0];
                    mrt_pkg::REG_TIMEOUT:      timeout_reg      <= cfg_data[31:0];
                    mrt_pkg::REG_MAP_LOW:      map_low_reg      <= cfg_data[15:0];
                    mrt_pkg::REG_MAP_HIGH:     map_high_reg     <= cfg_data[15:0];
                    mrt_pkg::REG_NUDGE:        nudge_reg        <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.apply)
            begin
                cur_max_reg  <= cur_max_next;
                cur_min_reg  <= cur_min_next;
                peak_max_reg <= peak_max_next;
                peak_min_reg <= peak_min_next;
                last_reg     <= last_next;
                tsm_reg      <= tsm_next;
                tsn_reg      <= tsn_next;
            end
        end
    end

    // ---- prep: average, signed differences as sign + magnitude ----
    logic [16:0] sum17;
    logic [15:0] avg_w;
    logic [16:0] diff_a, diff_b, diff_s;

    always_comb
    begin
        sum17  = {1'b0, cur_max_reg} + {1'b0, cur_min_reg};
        avg_w  = sum17[16:1];
        diff_a = {1'b0, avg_w} - {1'b0, peak_min_reg};
        diff_b = {1'b0, map_high_reg} - {1'b0, map_low_reg};
        diff_s = {1'b0, peak_max_reg} - {1'b0, peak_min_reg};
    end

    // ---- divider step ----
    logic [16:0] shifted;
    logic        ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[31]};
        ge       = shifted >= {1'b0, dsor_reg};
        rem_next = ge ? 16'(shifted - {1'b0, dsor_reg}) : shifted[15:0];
        quo_next = {quo_reg[30:0], ge};
    end

    assign status.div_done = cnt_reg == mrt_pkg::DIV_CNT_WIDTH'(mrt_pkg::DIV_STEPS - 1);

    // ---- result ----
    logic [15:0] q16, mapped_w;

    always_comb
    begin
        q16      = neg_reg ? 16'(-quo_reg[15:0]) : quo_reg[15:0];
        mapped_w = zero_reg ? map_low_reg : 16'(q16 + map_low_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            avg_reg    <= avg_w;
            mag_a_reg  <= diff_a[16] ? 16'(-diff_a) : diff_a[15:0];
            mag_b_reg  <= diff_b[16] ? 16'(-diff_b) : diff_b[15:0];
            dsor_reg   <= diff_s[16] ? 16'(-diff_s) : diff_s[15:0];
            neg_reg    <= diff_a[16] ^ diff_b[16] ^ diff_s[16];
            zero_reg   <= diff_s == 17'd0;
            motion_reg <= XW'(tsm_reg) < XW'(motion_hold_reg);
            tout_reg   <= XW'(tsm_reg) > XW'(timeout_reg);
        end
        if (cmd.mul)
        begin
            quo_reg <= {16'd0, mag_a_reg} * {16'd0, mag_b_reg};
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + mrt_pkg::DIV_CNT_WIDTH'(1);
        end
        if (cmd.out_load)
        begin
            mapped_reg     <= mapped_w;
            avg_out_reg    <= avg_reg;
            motion_out_reg <= motion_reg;
            tout_out_reg   <= tout_reg;
        end
    end

    assign mapped_level  = mapped_reg;
    assign range_average = avg_out_reg;
    assign motion_active = motion_out_reg;
    assign timed_out     = tout_out_reg;

endmodule

@@ sv/motion_range_tracker_unit.sv @@
// channel   dir  handshake      payload
// items     in   valid/ready    func[2:0], sample[15:0]
// results   out  valid/ready    mapped_level[15:0], range_average[15:0],
//                               motion_active, timed_out
// cfg       in   cfg_we only    cfg_index[2:0], cfg_data[31:0]
//
// Each item steps through accept, prep, multiply, the 32-step restoring divider
// (one quotient bit a cycle), then the result load; items are taken only when idle.
// Async active-low reset: config and tracker state take their reset values.
// The result sits in an output register; a stalled result beat only holds
// the finish step, and a new item beat may be taken while it waits.
module motion_range_tracker_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    mrt_in_if.sink                              items,
    mrt_out_if.source                           results,
    input  logic                                cfg_we,
    input  logic [mrt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mrt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    mrt_pkg::mrt_cmd_t    cmd;
    mrt_pkg::mrt_status_t status;

    // sequencer: accept, prep, mul, divide, finish
    mrt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // config, tracker state, map arithmetic, result register
    mrt_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (items.func),
        .sample        (items.sample),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mapped_level  (results.mapped_level),
        .range_average (results.range_average),
        .motion_active (results.motion_active),
        .timed_out     (results.timed_out)
    );

endmodule

@@ bench/motion_range_tracker_unit_test.sv @@
module motion_range_tracker_unit_test;

    // Unused func codes: the block must leave its state alone but still answer.
    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

    localparam int NUM_REGS      = 8;
    localparam int RESET_CYCLES  = 12;
    // Pad after the block drains, before touching config.
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any beat on either channel before we give up.
    localparam int STUCK_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 188;

    typedef struct packed {
        logic [15:0] mapped;
        logic [15:0] average;
        logic        motion;
        logic        timeout;
    } reading_t;

    typedef struct {
        int       seq;
        reading_t want;
    } pending_t;

    typedef struct {
        logic [15:0] limit;
        logic [15:0] quiet_hi;
        logic [15:0] quiet_lo;
        logic [31:0] hold;
        logic [31:0] timeout;
        logic [15:0] out_lo;
        logic [15:0] out_hi;
        logic [15:0] nudge_gap;
    } settings_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                                cfg_we;
    logic [mrt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [mrt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    mrt_in_if  item_bus();
    mrt_out_if result_bus();

    motion_range_tracker_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_bus),
        .results   (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Tracker state as the bench sees it, plus the register copy.
    // ------------------------------------------------------------------
    settings_t                       cfg;
    logic [15:0]                     range_hi, range_lo;   // current min/max
    logic [15:0]                     peak_hi, peak_lo;     // peak min/max
    logic [15:0]                     held_level;           // last clamped analog level
    logic [mrt_pkg::COUNT_WIDTH-1:0] ticks_motion;         // ticks since last motion
    logic [mrt_pkg::COUNT_WIDTH-1:0] ticks_nudge;          // ticks since honored decay

    pending_t pending_readings[$];
    int       items_sent = 0;
    int       mismatches = 0;
    int       send_idle_pct = 0;   // chance per cycle that the sender holds off
    int       stall_pct = 0;       // chance per cycle that the receiver stalls

    function automatic settings_t default_settings();
        settings_t st;
        st.limit     = mrt_pkg::RST_ANALOG_LIMIT;
        st.quiet_hi  = mrt_pkg::RST_QUIET_HIGH;
        st.quiet_lo  = mrt_pkg::RST_QUIET_LOW;
        st.hold      = mrt_pkg::RST_MOTION_HOLD;
        st.timeout   = mrt_pkg::RST_TIMEOUT;
        st.out_lo    = mrt_pkg::RST_MAP_LOW;
        st.out_hi    = mrt_pkg::RST_MAP_HIGH;
        st.nudge_gap = mrt_pkg::RST_NUDGE;
        return st;
    endfunction

    // Sample widens a range; only the max is clamped to the analog limit.
    function automatic void widen_range(inout logic [15:0] hi, inout logic [15:0] lo,
                                        input logic [15:0] smp);
        if (smp > hi)
            hi = smp;
        if (smp < lo)
            lo = smp;
        if (hi > cfg.limit)
            hi = cfg.limit;
    endfunction

    // Apply one item to the tracker copy and return the reading it yields.
    function automatic reading_t track_item(input logic [2:0] func, input logic [15:0] smp);
        logic [16:0] sum;
        longint      av_l, lo_l, hi_l, ml, mh, span, num, mapped;
        reading_t    r;
        case (func)
            mrt_pkg::FUNC_TICK:
            begin
                if (ticks_motion != mrt_pkg::CNT_MAX)
                    ticks_motion++;
                if (ticks_nudge != mrt_pkg::CNT_MAX)
                    ticks_nudge++;
            end
            mrt_pkg::FUNC_ANALOG:
            begin
                held_level = (smp < cfg.limit) ? smp : cfg.limit;
                widen_range(range_hi, range_lo, smp);
                widen_range(peak_hi, peak_lo, smp);
            end
            mrt_pkg::FUNC_DIGIT:
            begin
                if (smp != '0 || held_level > cfg.quiet_hi || held_level < cfg.quiet_lo)
                    ticks_motion = '0;
            end
            mrt_pkg::FUNC_DECAY:
            begin
                if (ticks_nudge >= cfg.nudge_gap)
                begin
                    ticks_nudge = '0;
                    if (peak_hi > cfg.quiet_hi)
                        peak_hi--;
                    if (peak_lo < cfg.quiet_lo)
                        peak_lo++;
                end
            end
            mrt_pkg::FUNC_CLEAR:
            begin
                range_hi = mrt_pkg::RANGE_MAX_EMPTY;
                range_lo = mrt_pkg::RANGE_MIN_EMPTY;
            end
            default: ;
        endcase

        sum  = {1'b0, range_hi} + {1'b0, range_lo};
        av_l = longint'(sum[16:1]);
        lo_l = longint'(peak_lo);
        hi_l = longint'(peak_hi);
        ml   = longint'(cfg.out_lo);
        mh   = longint'(cfg.out_hi);
        span = hi_l - lo_l;
        // signed map, truncating toward zero; inverted ranges go through as is
        if (span == 0)
            mapped = ml;
        else
        begin
            num    = (av_l - lo_l) * (mh - ml);
            mapped = num / span + ml;
        end

        r.mapped  = mapped[15:0];
        r.average = sum[16:1];
        r.motion  = (ticks_motion < cfg.hold);
        r.timeout = (ticks_motion > cfg.timeout);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Item driver: optional hold-off, then one beat. valid stays high into
    // the next item when there is no gap, so it is never dropped and raised
    // in the same step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] func, input logic [15:0] smp);
        pending_t p;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid  <= 1'b1;
        item_bus.func   <= func;
        item_bus.sample <= smp;
        @(posedge clk);
        while (item_bus.ready !== 1'b1)
            @(posedge clk);
        p.seq  = items_sent;
        p.want = track_item(func, smp);
        pending_readings.push_back(p);
        items_sent++;
    endtask

    task automatic wait_until_idle();
        item_bus.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Registers only change with the block drained. All eight are written.
    task automatic apply_settings(input settings_t st);
        logic [mrt_pkg::CFG_INDEX_WIDTH-1:0] idx;
        logic [mrt_pkg::CFG_DATA_WIDTH-1:0]  data;
        wait_until_idle();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            idx = i[mrt_pkg::CFG_INDEX_WIDTH-1:0];
            case (idx)
                mrt_pkg::REG_ANALOG_LIMIT: data = {16'd0, st.limit};
                mrt_pkg::REG_QUIET_HIGH:   data = {16'd0, st.quiet_hi};
                mrt_pkg::REG_QUIET_LOW:    data = {16'd0, st.quiet_lo};
                mrt_pkg::REG_MOTION_HOLD:  data = st.hold;
                mrt_pkg::REG_TIMEOUT:      data = st.timeout;
                mrt_pkg::REG_MAP_LOW:      data = {16'd0, st.out_lo};
                mrt_pkg::REG_MAP_HIGH:     data = {16'd0, st.out_hi};
                default:                   data = {16'd0, st.nudge_gap};
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cfg = st;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Fresh state: empty ranges give an inverted peak span; spare codes.
    task automatic test_reset_values();
        send_item(mrt_pkg::FUNC_TICK, 16'h0000);
        send_item(mrt_pkg::FUNC_CLEAR, 16'hFFFF);
        send_item(FUNC_UNUSED_FIRST, 16'hA5A5);
        send_item(FUNC_UNUSED_FIRST + 3'd1, 16'h5A5A);
        send_item(FUNC_UNUSED_LAST, 16'hFFFF);
    endtask

    // First sample sets peak min and max to the same value: zero span.
    task automatic test_zero_span();
        send_item(mrt_pkg::FUNC_ANALOG, 16'd700);
        send_item(mrt_pkg::FUNC_ANALOG, 16'd700);
    endtask

    // Sample extremes, clamp at the limit, motion from level and from line.
    task automatic test_analog_extremes();
        send_item(mrt_pkg::FUNC_ANALOG, 16'h0000);
        send_item(mrt_pkg::FUNC_DIGIT, 16'h0000);    // level below quiet band
        send_item(mrt_pkg::FUNC_ANALOG, 16'hFFFF);   // max clamps to limit
        send_item(mrt_pkg::FUNC_DIGIT, 16'hFFFF);
        send_item(mrt_pkg::FUNC_ANALOG, 16'd420);
        send_item(mrt_pkg::FUNC_DIGIT, 16'h0000);    // inside band: no motion
    endtask

    // map_low above map_high runs the same signed formula.
    task automatic test_map_inverted();
        settings_t st;
        st = default_settings();
        st.out_lo = 16'hFFFF;
        st.out_hi = 16'h0000;
        apply_settings(st);
        send_item(mrt_pkg::FUNC_ANALOG, 16'd300);
        send_item(mrt_pkg::FUNC_CLEAR, 16'h0000);
        send_item(mrt_pkg::FUNC_ANALOG, 16'd1000);
    endtask

    // Decay honored with no interval, then held off until ticks catch up.
    task automatic test_decay();
        settings_t st;
        st = default_settings();
        st.nudge_gap = 16'd0;
        apply_settings(st);
        send_item(mrt_pkg::FUNC_DECAY, 16'h0000);
        st.nudge_gap = 16'd2;
        apply_settings(st);
        send_item(mrt_pkg::FUNC_DECAY, 16'h0000);    // too early
        send_item(mrt_pkg::FUNC_TICK, 16'h0000);
        send_item(mrt_pkg::FUNC_TICK, 16'h0000);
        send_item(mrt_pkg::FUNC_DECAY, 16'h0000);    // interval reached
    endtask

    // Short hold and timeout so both flags flip within a few ticks.
    task automatic test_motion_window();
        settings_t st;
        st = default_settings();
        st.hold    = 32'd1;
        st.timeout = 32'd2;
        apply_settings(st);
        send_item(mrt_pkg::FUNC_DIGIT, 16'h0001);
        send_item(mrt_pkg::FUNC_TICK, 16'h0000);
        send_item(mrt_pkg::FUNC_TICK, 16'h0000);
        send_item(mrt_pkg::FUNC_TICK, 16'h0000);
        send_item(mrt_pkg::FUNC_DIGIT, 16'h0001);
    endtask

    // ------------------------------------------------------------------
    // Random phases: short windows first, then register extremes, then random
    // settings; the idle pattern rotates through none / sender / receiver / both.
    // ------------------------------------------------------------------
    task automatic test_random_phase(input int phase, input int count);
        settings_t   st;
        int          sent;
        int          pick;
        logic [2:0]  func;
        logic [15:0] smp;
        st = default_settings();
        case (phase)
            0:
            begin
                st.hold      = 32'd20;
                st.timeout   = 32'd40;
                st.nudge_gap = 16'd5;
            end
            1:
            begin
                st.limit     = 16'hFFFF;
                st.quiet_hi  = 16'hFFFF;
                st.quiet_lo  = 16'h0000;
                st.hold      = 32'h0000_0000;
                st.timeout   = 32'h0000_0000;
                st.out_lo    = 16'h0000;
                st.out_hi    = 16'hFFFF;
                st.nudge_gap = 16'h0000;
            end
            2:
            begin
                st.limit     = 16'h0000;
                st.quiet_hi  = 16'h0000;
                st.quiet_lo  = 16'hFFFF;
                st.hold      = 32'hFFFF_FFFF;
                st.timeout   = 32'hFFFF_FFFF;
                st.out_lo    = 16'hFFFF;
                st.out_hi    = 16'h0000;
                st.nudge_gap = 16'hFFFF;
            end
            default:
            begin
                st.limit     = 16'($urandom_range(65535, 200));
                st.quiet_hi  = 16'($urandom_range(2000, 0));
                st.quiet_lo  = 16'($urandom_range(2000, 0));
                st.hold      = $urandom_range(60, 0);
                st.timeout   = $urandom_range(100, 0);
                st.out_lo    = 16'($urandom());
                st.out_hi    = 16'($urandom());
                st.nudge_gap = 16'($urandom_range(12, 0));
            end
        endcase
        apply_settings(st);

        case (phase % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 69; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 69; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
        endcase

        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99, 0);
            smp  = 16'($urandom());
            if (pick < 3)
            begin
                // tick run of 10 to 60 items, which can cross hold and timeout
                repeat ($urandom_range(60, 10))
                begin
                    send_item(mrt_pkg::FUNC_TICK, 16'($urandom()));
                    sent++;
                end
            end
            else
            begin
                if (pick < 36)
                    func = mrt_pkg::FUNC_TICK;
                else if (pick < 56)
                begin
                    func = mrt_pkg::FUNC_ANALOG;
                    // half the samples near the quiet band
                    if ($urandom_range(1, 0) == 1)
                        smp = 16'($urandom_range(2047, 0));
                end
                else if (pick < 72)
                begin
                    func = mrt_pkg::FUNC_DIGIT;
                    if ($urandom_range(2, 0) != 0)
                        smp = '0;
                end
                else if (pick < 86)
                    func = mrt_pkg::FUNC_DECAY;
                else if (pick < 93)
                    func = mrt_pkg::FUNC_CLEAR;
                else
                    func = 3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
                send_item(func, smp);
                sent++;
            end
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall on ready, each beat checked against the
    // oldest pending reading.
    // ------------------------------------------------------------------
    initial
    begin
        pending_t p;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (pending_readings.size() == 0)
                    report_mismatch("result beat with no item outstanding");
                else
                begin
                    p = pending_readings.pop_front();
                    if (result_bus.mapped_level !== p.want.mapped)
                        report_mismatch($sformatf("item %0d mapped_level %0h, want %0h",
                                        p.seq, result_bus.mapped_level, p.want.mapped));
                    if (result_bus.range_average !== p.want.average)
                        report_mismatch($sformatf("item %0d range_average %0h, want %0h",
                                        p.seq, result_bus.range_average, p.want.average));
                    if (result_bus.motion_active !== p.want.motion)
                        report_mismatch($sformatf("item %0d motion_active %b, want %b",
                                        p.seq, result_bus.motion_active, p.want.motion));
                    if (result_bus.timed_out !== p.want.timeout)
                        report_mismatch($sformatf("item %0d timed_out %b, want %b",
                                        p.seq, result_bus.timed_out, p.want.timeout));
                end
            end
            result_bus.ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Watchdog: any beat on either side clears the count.
    initial
    begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("watchdog: no beat for %0d cycles, %0d readings outstanding",
                 STUCK_LIMIT, pending_readings.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        item_bus.valid  = 1'b0;
        item_bus.func   = mrt_pkg::FUNC_TICK;
        item_bus.sample = '0;
        cfg_we          = 1'b0;
        cfg_index       = mrt_pkg::REG_ANALOG_LIMIT;
        cfg_data        = '0;

        cfg          = default_settings();
        range_hi     = mrt_pkg::RANGE_MAX_EMPTY;
        range_lo     = mrt_pkg::RANGE_MIN_EMPTY;
        peak_hi      = mrt_pkg::RANGE_MAX_EMPTY;
        peak_lo      = mrt_pkg::RANGE_MIN_EMPTY;
        held_level   = mrt_pkg::RST_LAST_LEVEL;
        ticks_motion = '0;
        ticks_nudge  = '0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_zero_span();
        test_analog_extremes();
        test_map_inverted();
        test_decay();
        test_motion_window();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            test_random_phase(ph, PHASE_ITEMS);

        wait_until_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
